>>> src/ppds_pkg.sv
// Shared constants for the point pair distance statistics block.
// No dependencies.
package ppds_pkg;
  localparam int DIST_W = 25;
  localparam int VAR_W = 50;
endpackage

>>> src/point_pair_distance_statistics.sv
// Point pair distance statistics top level: input control, distance store,
// variance pass and result register. Uses ppds_pkg, ppds_ram, ppds_root, ppds_div.
//
//  channel | signals                               | direction
//  in      | in_valid, in_stall, a_*, b_*, last_pair | pair in
//  out     | out_valid, out_stall, result fields    | statistics out
//
// Each pair is worked through the root unit before the next pair is taken.
// A last pair of a non-empty set adds two divisions, for mean and variance,
// and a store pass through the single read port.
// Reset clears the set statistics; the store itself needs no clearing.
// A result waiting under out_stall holds only the next result, not new pairs.
module point_pair_distance_statistics
  import ppds_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_WIDTH-1:0]  a_x,
  input  logic signed [COORD_WIDTH-1:0]  a_y,
  input  logic signed [COORD_WIDTH-1:0]  a_z,
  input  logic signed [COORD_WIDTH-1:0]  b_x,
  input  logic signed [COORD_WIDTH-1:0]  b_y,
  input  logic signed [COORD_WIDTH-1:0]  b_z,
  input  logic                           last_pair,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [DIST_W-1:0]              max_distance,
  output logic [DIST_W-1:0]              min_distance,
  output logic [VAR_W-1:0]               distance_variance,
  output logic [$clog2(MAX_POINTS+1)-1:0] pair_count,
  output logic                           overflow
);
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = DIST_W + AW;
  localparam int ACC_W = 2 * DIST_W + AW;

  typedef enum logic [2:0] {S_IDLE, S_DIST, S_FIN, S_MEAN, S_PASS, S_VAR, S_OUT} state_t;

  state_t                   state;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic                     last_r;
  logic                     root_start;
  logic                     root_done;
  logic [DIFF_W:0]          root;
  logic [DIST_W-1:0]        pair_dist;
  logic [CNT_W-1:0]         pairs_seen;
  logic [SUM_W-1:0]         dist_sum;
  logic [DIST_W-1:0]        run_max, run_min;
  logic                     dropped;
  logic [DIST_W-1:0]        mean;
  logic [ACC_W-1:0]         acc;
  logic [CNT_W-1:0]         rd_idx;
  logic                     v1, v2, v3;
  logic [DIST_W-1:0]        mag;
  logic [2*DIST_W-1:0]      sq;
  logic [VAR_W-1:0]         var_r;
  logic                     full;
  logic                     we;
  logic [DIST_W-1:0]        rdata;
  logic                     div_start, div_done;
  logic [ACC_W-1:0]         div_num, div_quo;
  logic                     pass_end;

  assign in_stall = (state != S_IDLE);
  assign pair_dist = DIST_W'(root);
  assign full = (pairs_seen == CNT_W'(MAX_POINTS));
  assign we = (state == S_DIST) && root_done && !full;
  assign pass_end = (state == S_PASS) && (rd_idx == pairs_seen) && !v1 && !v2 && !v3;
  assign div_start = ((state == S_FIN) && (pairs_seen != '0)) || pass_end;
  assign div_num = (state == S_FIN) ? ACC_W'(dist_sum) : acc;

  ppds_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_store (
    .clk(clk), .we(we), .waddr(pairs_seen[AW-1:0]), .wdata(pair_dist),
    .raddr(rd_idx[AW-1:0]), .rdata(rdata)
  );

  ppds_root #(.DIFF_W(DIFF_W)) u_root (
    .clk(clk), .rst(rst), .start(root_start), .dx(dx), .dy(dy), .dz(dz),
    .done(root_done), .root(root)
  );

  ppds_div #(.NUM_W(ACC_W), .DEN_W(CNT_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(pairs_seen),
    .done(div_done), .quot(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      root_start <= 1'b0;
      pairs_seen <= '0;
      dist_sum <= '0;
      run_max <= '0;
      run_min <= '1;
      dropped <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      rd_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      root_start <= (state == S_IDLE) && in_valid;
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            dx <= DIFF_W'(a_x) - DIFF_W'(b_x);
            dy <= DIFF_W'(a_y) - DIFF_W'(b_y);
            dz <= DIFF_W'(a_z) - DIFF_W'(b_z);
            last_r <= last_pair;
            state <= S_DIST;
          end
        end
        S_DIST: begin
          if (root_done) begin
            if (!full) begin
              pairs_seen <= pairs_seen + 1'b1;
              dist_sum <= dist_sum + SUM_W'(pair_dist);
              if (pair_dist > run_max) begin
                run_max <= pair_dist;
              end
              if (pair_dist < run_min) begin
                run_min <= pair_dist;
              end
            end else begin
              dropped <= 1'b1;
            end
            state <= last_r ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (pairs_seen == '0) begin
            var_r <= '0;
            state <= S_OUT;
          end else begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean <= DIST_W'(div_quo);
            acc <= '0;
            rd_idx <= '0;
            v1 <= 1'b0;
            v2 <= 1'b0;
            v3 <= 1'b0;
            state <= S_PASS;
          end
        end
        S_PASS: begin
          if (rd_idx != pairs_seen) begin
            rd_idx <= rd_idx + 1'b1;
            v1 <= 1'b1;
          end else begin
            v1 <= 1'b0;
          end
          v2 <= v1;
          mag <= (rdata >= mean) ? rdata - mean : mean - rdata;
          v3 <= v2;
          sq <= mag * mag;
          if (v3) begin
            acc <= acc + ACC_W'(sq);
          end
          if (pass_end) begin
            state <= S_VAR;
          end
        end
        S_VAR: begin
          if (div_done) begin
            var_r <= VAR_W'(div_quo);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            max_distance <= run_max;
            min_distance <= run_min;
            distance_variance <= var_r;
            pair_count <= pairs_seen;
            overflow <= dropped;
            pairs_seen <= '0;
            dist_sum <= '0;
            run_max <= '0;
            run_min <= '1;
            dropped <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pairs_seen <= CNT_W'(MAX_POINTS))
    else $error("pair count beyond store depth");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second pair taken while one is in work");

  a_pass_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS) |-> (pairs_seen != '0))
    else $error("variance pass over an empty set");

  a_write_only_loading: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_DIST) && (pairs_seen < CNT_W'(MAX_POINTS)))
    else $error("store written outside loading");
`endif
endmodule

>>> src/ppds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppds_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/ppds_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module ppds_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;

  assign shifted = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NUM_W);
        q <= num;
        rem <= '0;
        den_r <= den;
      end else if (busy) begin
        if (shifted >= {1'b0, den_r}) begin
          rem <= shifted - {1'b0, den_r};
          q <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

>>> src/ppds_root.sv
// Distance unit: squares the coordinate differences, sums them and takes
// the truncated square root, two radicand bits per cycle. No dependencies.
module ppds_root #(
  parameter int DIFF_W = 25
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  input  logic signed [DIFF_W-1:0] dz,
  output logic                     done,
  output logic [DIFF_W:0]          root
);
  localparam int RT_W = DIFF_W + 1;
  localparam int SQ_W = 2 * RT_W;
  localparam int REM_W = RT_W + 3;
  localparam int CW = $clog2(RT_W + 1);

  typedef enum logic [1:0] {R_IDLE, R_SQ, R_ADD, R_ITER} rstate_t;

  rstate_t           state;
  logic [CW-1:0]     cnt;
  logic [DIFF_W-1:0] mx, my, mz;
  logic [2*DIFF_W-1:0] sx, sy, sz;
  logic [SQ_W-1:0]   op;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  remv;
  logic [REM_W-1:0]  trial;

  assign remv = {rem[REM_W-3:0], op[SQ_W-1:SQ_W-2]};
  assign trial = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= (state == R_ITER) && (cnt == CW'(1));
      unique case (state)
        R_IDLE: begin
          if (start) begin
            mx <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
            my <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            mz <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
            state <= R_SQ;
          end
        end
        R_SQ: begin
          sx <= mx * mx;
          sy <= my * my;
          sz <= mz * mz;
          state <= R_ADD;
        end
        R_ADD: begin
          op <= SQ_W'(sx) + SQ_W'(sy) + SQ_W'(sz);
          rem <= '0;
          root <= '0;
          cnt <= CW'(RT_W);
          state <= R_ITER;
        end
        R_ITER: begin
          if (remv >= trial) begin
            rem <= remv - trial;
            root <= {root[RT_W-2:0], 1'b1};
          end else begin
            rem <= remv;
            root <= {root[RT_W-2:0], 1'b0};
          end
          op <= {op[SQ_W-3:0], 2'b00};
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end
endmodule
